>>> sv/dnl_pkg.sv
// Package for the delimiter nesting length block: constants, codes and the
// structs passed between the configuration registers, the scan core and the top.
// No dependencies.
`timescale 1ns / 1ps

package dnl_pkg;

  // Default sizes of the block.
  localparam int MAX_DELIM_DEF  = 8;
  localparam int COUNT_BITS_DEF = 24;

  // Fixed field widths.
  localparam int CH_W       = 8;
  localparam int STATUS_W   = 2;
  localparam int SPAN_W     = 25;
  localparam int PATTERN_W  = 64;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Register reset values: '(' and ')' of one byte each.
  localparam logic [PATTERN_W-1:0] OPEN_PATTERN_RST  = 64'd40;
  localparam logic [PATTERN_W-1:0] CLOSE_PATTERN_RST = 64'd41;
  localparam logic [LEN_W-1:0]     OPEN_LEN_RST      = 4'd1;
  localparam logic [LEN_W-1:0]     CLOSE_LEN_RST     = 4'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_PATTERN  = 8'd0,
    REG_OPEN_LENGTH   = 8'd1,
    REG_CLOSE_PATTERN = 8'd2,
    REG_CLOSE_LENGTH  = 8'd3
  } dnl_reg_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_CLOSED   = 2'd0,
    ST_STRAY    = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_OVERFLOW = 2'd3
  } dnl_status_e;

  // Delimiter settings with lengths already clamped to the usable range.
  typedef struct packed {
    logic [PATTERN_W-1:0] open_pattern;
    logic [LEN_W-1:0]     open_len;
    logic [PATTERN_W-1:0] close_pattern;
    logic [LEN_W-1:0]     close_len;
  } dnl_cfg_t;

  // One result word leaving the scan core.
  typedef struct packed {
    logic              valid;
    dnl_status_e       status;
    logic [SPAN_W-1:0] span_length;
  } dnl_result_t;

endpackage

>>> sv/dnl_cfg_regs.sv
// Configuration register file of the delimiter nesting length block.
// Holds the two delimiter patterns and lengths; clamps the lengths.
// Depends on dnl_pkg.
`timescale 1ns / 1ps

module dnl_cfg_regs #(
  parameter int MaxDelim = dnl_pkg::MAX_DELIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dnl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dnl_pkg::PATTERN_W-1:0] cfg_data_i,
  output dnl_pkg::dnl_cfg_t             cfg_o
);
  import dnl_pkg::*;

  logic [PATTERN_W-1:0] open_pat_q, open_pat_d;
  logic [PATTERN_W-1:0] close_pat_q, close_pat_d;
  logic [LEN_W-1:0]     open_len_q, open_len_d;
  logic [LEN_W-1:0]     close_len_q, close_len_d;

  // Register write decode.
  always_comb begin
    open_pat_d  = open_pat_q;
    close_pat_d = close_pat_q;
    open_len_d  = open_len_q;
    close_len_d = close_len_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OPEN_PATTERN:  open_pat_d  = cfg_data_i;
        REG_OPEN_LENGTH:   open_len_d  = cfg_data_i[LEN_W-1:0];
        REG_CLOSE_PATTERN: close_pat_d = cfg_data_i;
        REG_CLOSE_LENGTH:  close_len_d = cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_pat_q  <= OPEN_PATTERN_RST;
      close_pat_q <= CLOSE_PATTERN_RST;
      open_len_q  <= OPEN_LEN_RST;
      close_len_q <= CLOSE_LEN_RST;
    end else begin
      open_pat_q  <= open_pat_d;
      close_pat_q <= close_pat_d;
      open_len_q  <= open_len_d;
      close_len_q <= close_len_d;
    end
  end

  // A length of zero acts as one; anything above the window depth acts as the depth.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(MaxDelim)) begin
      res = LEN_W'(MaxDelim);
    end else begin
      res = len;
    end
    return res;
  endfunction

  always_comb begin
    cfg_o.open_pattern  = open_pat_q;
    cfg_o.open_len      = clamp_len(open_len_q);
    cfg_o.close_pattern = close_pat_q;
    cfg_o.close_len     = clamp_len(close_len_q);
  end

endmodule

>>> sv/dnl_scan_core.sv
// Scan core of the delimiter nesting length block: lookahead byte window,
// delimiter compare, nesting level, position count and held outcome.
// Depends on dnl_pkg.
`timescale 1ns / 1ps

module dnl_scan_core #(
  parameter int MaxDelim  = dnl_pkg::MAX_DELIM_DEF,
  parameter int CountBits = dnl_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dnl_pkg::dnl_cfg_t        cfg_i,
  input  logic                     item_valid_i,
  input  logic [dnl_pkg::CH_W-1:0] item_ch_i,
  input  logic                     out_free_i,
  output logic                     consume_o,
  output dnl_pkg::dnl_result_t     res_o
);
  import dnl_pkg::*;

  localparam int FillW = $clog2(MaxDelim + 1);
  localparam int SumW  = CountBits + 1;

  logic [CH_W-1:0]      win_q [MaxDelim];
  logic [CH_W-1:0]      win_d [MaxDelim];
  logic [CH_W-1:0]      ew    [MaxDelim];
  logic [FillW-1:0]     fill_q, fill_d, ef;
  logic [CountBits-1:0] level_q, level_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 decided_q, decided_d;
  dnl_status_e          hstat_q, hstat_d;
  logic [SPAN_W-1:0]    hlen_q, hlen_d;

  logic [LEN_W-1:0] need, have;
  logic             is_term, do_eval, do_append, do_clear;
  logic             open_hit, close_hit;

  // Decide what this cycle does with the held byte.
  always_comb begin
    need      = (cfg_i.close_len > cfg_i.open_len) ? cfg_i.close_len : cfg_i.open_len;
    have      = LEN_W'(fill_q);
    is_term   = (item_ch_i == '0);
    do_eval   = 1'b0;
    do_append = 1'b0;
    do_clear  = 1'b0;
    consume_o = 1'b0;
    if (item_valid_i) begin
      if (is_term) begin
        // Drain the window one position a cycle, then report.
        if (!decided_q && (fill_q != '0)) begin
          do_eval = 1'b1;
        end else if (out_free_i) begin
          do_clear  = 1'b1;
          consume_o = 1'b1;
        end
      end else if (decided_q) begin
        consume_o = 1'b1;
      end else if (have >= need) begin
        // Lengths shrank since the last byte: catch up before appending.
        do_eval = 1'b1;
      end else begin
        do_append = 1'b1;
        consume_o = 1'b1;
        do_eval   = ((have + LEN_W'(1)) >= need);
      end
    end
  end

  // Window as seen by the compare, with the new byte placed when appending.
  always_comb begin
    for (int i = 0; i < MaxDelim; i++) begin
      ew[i] = (do_append && (FillW'(i) == fill_q)) ? item_ch_i : win_q[i];
    end
    ef = do_append ? fill_q + FillW'(1) : fill_q;
  end

  // Delimiter compares over the front of the window; a match must fit the fill.
  always_comb begin
    open_hit  = (cfg_i.open_len <= LEN_W'(ef));
    close_hit = (cfg_i.close_len <= LEN_W'(ef));
    for (int i = 0; i < MaxDelim; i++) begin
      if ((LEN_W'(i) < cfg_i.open_len) &&
          (ew[i] != cfg_i.open_pattern[CH_W*i +: CH_W])) begin
        open_hit = 1'b0;
      end
      if ((LEN_W'(i) < cfg_i.close_len) &&
          (ew[i] != cfg_i.close_pattern[CH_W*i +: CH_W])) begin
        close_hit = 1'b0;
      end
    end
  end

  // Evaluate the front position and update level, count and outcome.
  always_comb begin
    level_d   = level_q;
    count_d   = count_q;
    decided_d = decided_q;
    hstat_d   = hstat_q;
    hlen_d    = hlen_q;
    fill_d    = fill_q;
    for (int i = 0; i < MaxDelim; i++) begin
      win_d[i] = ew[i];
    end
    if (do_eval) begin
      if (open_hit) begin
        if (level_q != '1) begin
          level_d = level_q + CountBits'(1);
        end
      end else if (close_hit) begin
        if (level_q == '0) begin
          decided_d = 1'b1;
          hstat_d   = ST_STRAY;
        end else if (level_q == CountBits'(1)) begin
          decided_d = 1'b1;
          hstat_d   = ST_CLOSED;
          hlen_d    = SPAN_W'({1'b0, count_q} + SumW'(cfg_i.close_len));
        end else begin
          level_d = level_q - CountBits'(1);
        end
      end
      if (!decided_d) begin
        if (count_q == '1) begin
          decided_d = 1'b1;
          hstat_d   = ST_OVERFLOW;
        end else begin
          count_d = count_q + CountBits'(1);
        end
      end
      // Drop the evaluated position from the window.
      for (int i = 0; i < MaxDelim - 1; i++) begin
        win_d[i] = ew[i + 1];
      end
      fill_d = ef - FillW'(1);
    end else if (do_append) begin
      fill_d = ef;
    end
    if (do_clear) begin
      fill_d    = '0;
      level_d   = '0;
      count_d   = '0;
      decided_d = 1'b0;
      hstat_d   = ST_CLOSED;
      hlen_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      level_q   <= '0;
      count_q   <= '0;
      decided_q <= 1'b0;
      hstat_q   <= ST_CLOSED;
      hlen_q    <= '0;
    end else begin
      fill_q    <= fill_d;
      level_q   <= level_d;
      count_q   <= count_d;
      decided_q <= decided_d;
      hstat_q   <= hstat_d;
      hlen_q    <= hlen_d;
    end
  end

  // Window bytes are payload; the fill count says which are meaningful.
  always_ff @(posedge clk_i) begin
    if (do_eval || do_append) begin
      for (int i = 0; i < MaxDelim; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // Result on the terminator: the held outcome, or no closer found.
  always_comb begin
    res_o.valid       = do_clear;
    res_o.status      = decided_q ? hstat_q : ST_UNCLOSED;
    res_o.span_length = (decided_q && (hstat_q == ST_CLOSED)) ? hlen_q : '0;
  end

endmodule

>>> sv/delimiter_nesting_length.sv
// Top level of the delimiter nesting length block: input word register,
// output register, configuration registers and the scan core.
// Depends on dnl_pkg, dnl_cfg_regs and dnl_scan_core.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata[7:0] ch
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata[24:0] span_length, tuser[1:0] status
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// A string byte is appended to the lookahead window and, once the window holds
// enough bytes for the longer delimiter, the front position is compared in the
// same cycle; bytes stream at one per clock except after a length shrinks, when
// the next byte waits while surplus positions are evaluated. The terminator
// drains the window (at most MaxDelim - 1 bytes), then loads the result register.
// Reset clears all control state; the output register parts stalls on m_axis
// from input acceptance except while a result is still waiting to leave.

module delimiter_nesting_length #(
  parameter int MaxDelim  = dnl_pkg::MAX_DELIM_DEF,
  parameter int CountBits = dnl_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dnl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] ch
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [dnl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [24:0] span_length, zero above
  output logic [dnl_pkg::STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dnl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dnl_pkg::PATTERN_W-1:0]   cfg_data_i
);
  import dnl_pkg::*;

  dnl_cfg_t    cfg;
  dnl_result_t res;
  logic        consume, out_free;

  logic              in_valid_q, in_valid_d;
  logic [CH_W-1:0]   in_ch_q;
  logic              out_valid_q, out_valid_d;
  dnl_status_e       out_status_q;
  logic [SPAN_W-1:0] out_span_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  dnl_cfg_regs #(
    .MaxDelim (MaxDelim)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input word register: refilled in the cycle its word is consumed.
  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (consume) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q <= s_axis_tdata[CH_W-1:0];
    end
  end

  dnl_scan_core #(
    .MaxDelim  (MaxDelim),
    .CountBits (CountBits)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (in_valid_q),
    .item_ch_i    (in_ch_q),
    .out_free_i   (out_free),
    .consume_o    (consume),
    .res_o        (res)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_status_q <= res.status;
      out_span_q   <= res.span_length;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_span_q);
  assign m_axis_tuser  = out_status_q;

endmodule
